FILE: rtl/triangle_contour_crossing_top_assert.svh
// ----------------------------------------------------------------------------
// triangle_contour_crossing_top_assert.svh
// Assertion macros shared by the contour crossing RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CONTOUR_CROSSING_TOP_ASSERT_SVH
`define TRIANGLE_CONTOUR_CROSSING_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Types, location codes and helper functions of the contour crossing block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_pkg;

    localparam logic [2:0] WHERE_NONE = 3'd0;
    localparam logic [2:0] WHERE_V0   = 3'd1;
    localparam logic [2:0] WHERE_V1   = 3'd2;
    localparam logic [2:0] WHERE_V2   = 3'd3;
    localparam logic [2:0] WHERE_E0   = 3'd4;
    localparam logic [2:0] WHERE_E1   = 3'd5;
    localparam logic [2:0] WHERE_E2   = 3'd6;

    localparam int NUM_DIV_STEPS = 32;

    typedef struct packed {
        logic [2:0] entry_where;
        logic [2:0] exit_where;
    } ctl_t;

    typedef struct packed {
        logic        is_edge;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] y1;
        logic [31:0] y2;
    } sel_lane_t;

    typedef struct packed {
        logic        is_edge;
        logic        neg;
        logic [31:0] y1;
        logic [31:0] num_mag;
        logic [32:0] diff_mag;
        logic [32:0] den_mag;
    } mul_lane_t;

    typedef struct packed {
        logic        is_edge;
        logic        neg;
        logic [31:0] y1;
        logic [32:0] den;
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] q;
    } div_lane_t;

    // location codes from on-level and below-level flags of the vertices
    function automatic ctl_t decode_where(input logic [2:0] z, input logic [2:0] n);
        ctl_t c;
        c.entry_where = WHERE_NONE;
        c.exit_where  = WHERE_NONE;
        priority if (z[0] && z[1] && z[2]) begin
            c.entry_where = WHERE_NONE;
        end else if (z[0] && z[1]) begin
            c.entry_where = WHERE_V0;  c.exit_where = WHERE_V1;
        end else if (z[0] && z[2]) begin
            c.entry_where = WHERE_V0;  c.exit_where = WHERE_V2;
        end else if (z[1] && z[2]) begin
            c.entry_where = WHERE_V1;  c.exit_where = WHERE_V2;
        end else if (z[0]) begin
            if (n[1] != n[2]) begin
                c.entry_where = WHERE_V0;  c.exit_where = WHERE_E1;
            end
        end else if (z[1]) begin
            if (n[0] != n[2]) begin
                c.entry_where = WHERE_V1;  c.exit_where = WHERE_E2;
            end
        end else if (z[2]) begin
            if (n[0] != n[1]) begin
                c.entry_where = WHERE_V2;  c.exit_where = WHERE_E0;
            end
        end else if ((n[0] != n[1]) && (n[1] != n[2])) begin
            c.entry_where = WHERE_E0;  c.exit_where = WHERE_E1;
        end else if ((n[0] != n[1]) && (n[2] != n[0])) begin
            c.entry_where = WHERE_E0;  c.exit_where = WHERE_E2;
        end else if ((n[1] != n[2]) && (n[2] != n[0])) begin
            c.entry_where = WHERE_E1;  c.exit_where = WHERE_E2;
        end else begin
            c.exit_where = WHERE_NONE;
        end
        return c;
    endfunction

    // one restoring division step
    function automatic div_lane_t div_step(input div_lane_t d);
        div_lane_t   r;
        logic [33:0] sh;
        logic [33:0] diff;
        r    = d;
        sh   = {d.rem, d.low[31]};
        diff = sh - {1'b0, d.den};
        r.low = {d.low[30:0], 1'b0};
        if (!diff[33]) begin
            r.rem = diff[32:0];
            r.q   = {d.q[30:0], 1'b1};
        end else begin
            r.rem = sh[32:0];
            r.q   = {d.q[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: rtl/triangle_contour_crossing_top.sv
// ----------------------------------------------------------------------------
// triangle_contour_crossing_top
// Marching-triangles isoline crossing: entry and exit points of one triangle.
// ----------------------------------------------------------------------------
//  channel | ports        | moves
//  --------+--------------+--------------------------------------------
//  input   | s_valid/ready| one triangle: three values, three positions
//  config  | cfg_valid/rdy| contour level, always ready
//  result  | m_valid/ready| entry/exit points, location codes, crossed
//
//  One request per cycle unless the result stalls; each of six lanes runs a
//  32x33 multiplier into a 32-step pipelined restoring divider.
//  Synchronous active-low reset clears valid bits and the level.
//  A stalled result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_contour_crossing_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_value_a,
    input  logic signed [31:0] s_value_b,
    input  logic signed [31:0] s_value_c,
    input  logic signed [31:0] s_a_x,
    input  logic signed [31:0] s_a_y,
    input  logic signed [31:0] s_a_z,
    input  logic signed [31:0] s_b_x,
    input  logic signed [31:0] s_b_y,
    input  logic signed [31:0] s_b_z,
    input  logic signed [31:0] s_c_x,
    input  logic signed [31:0] s_c_y,
    input  logic signed [31:0] s_c_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_entry_x,
    output logic signed [31:0] m_entry_y,
    output logic signed [31:0] m_entry_z,
    output logic signed [31:0] m_exit_x,
    output logic signed [31:0] m_exit_y,
    output logic signed [31:0] m_exit_z,
    output logic        [2:0]  m_entry_where,
    output logic        [2:0]  m_exit_where,
    output logic               m_crossed
);
    import tcc_pkg::*;
`include "triangle_contour_crossing_top_assert.svh"

    localparam int NCTL = NUM_DIV_STEPS + 3;

    logic [31:0] level_reg;
    logic        advance;

    logic [NCTL-1:0] valid_reg;
    ctl_t            ctl_reg [NCTL];

    sel_lane_t       sel_next  [6];
    sel_lane_t       sel_reg   [6];
    mul_lane_t       mul_reg   [6];
    mul_lane_t       mul_next  [6];
    div_lane_t       div_reg   [6][NUM_DIV_STEPS+1];
    div_lane_t       div0_next [6];
    ctl_t            ctl_next;

    logic        out_valid_reg;
    logic [5:0][31:0] out_reg, out_next;
    ctl_t        out_ctl_reg;

    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (cfg_valid) begin
            level_reg <= cfg_data;
        end
    end

    // stage A: classify vertices and pick edge end points
    always_comb begin
        logic [2:0][31:0]      val;
        logic [2:0][2:0][31:0] pos;
        logic [32:0]           dk;
        logic [2:0]            z, n;
        logic [2:0]            w;
        logic [1:0]            p, q;
        val = {s_value_c, s_value_b, s_value_a};
        pos[0] = {s_a_z, s_a_y, s_a_x};
        pos[1] = {s_b_z, s_b_y, s_b_x};
        pos[2] = {s_c_z, s_c_y, s_c_x};
        for (int k = 0; k < 3; k++) begin
            dk   = {val[k][31], val[k]} - {level_reg[31], level_reg};
            z[k] = (dk == '0);
            n[k] = dk[32];
        end
        ctl_next = decode_where(z, n);
        for (int s = 0; s < 2; s++) begin
            w = (s == 0) ? ctl_next.entry_where : ctl_next.exit_where;
            unique case (w)
                WHERE_V0: begin p = 2'd0; q = 2'd0; end
                WHERE_V1: begin p = 2'd1; q = 2'd1; end
                WHERE_V2: begin p = 2'd2; q = 2'd2; end
                WHERE_E0: begin p = 2'd0; q = 2'd1; end
                WHERE_E1: begin p = 2'd2; q = 2'd1; end
                WHERE_E2: begin p = 2'd0; q = 2'd2; end
                default:  begin p = 2'd3; q = 2'd3; end
            endcase
            for (int c = 0; c < 3; c++) begin
                sel_next[s*3+c].is_edge = (w >= WHERE_E0) && (w <= WHERE_E2);
                if (p == 2'd3) begin
                    sel_next[s*3+c].x1 = '0;
                    sel_next[s*3+c].x2 = '0;
                    sel_next[s*3+c].y1 = '0;
                    sel_next[s*3+c].y2 = '0;
                end else begin
                    sel_next[s*3+c].x1 = val[p];
                    sel_next[s*3+c].x2 = val[q];
                    sel_next[s*3+c].y1 = pos[p][c];
                    sel_next[s*3+c].y2 = pos[q][c];
                end
            end
        end
    end

    // stage B: offsets, magnitudes and sign of the quotient
    always_comb begin
        logic [33:0] num, den, dif;
        for (int l = 0; l < 6; l++) begin
            num = {{2{level_reg[31]}}, level_reg} - {{2{sel_reg[l].x1[31]}}, sel_reg[l].x1};
            den = {{2{sel_reg[l].x2[31]}}, sel_reg[l].x2}
                - {{2{sel_reg[l].x1[31]}}, sel_reg[l].x1};
            dif = {{2{sel_reg[l].y2[31]}}, sel_reg[l].y2}
                - {{2{sel_reg[l].y1[31]}}, sel_reg[l].y1};
            mul_next[l].is_edge  = sel_reg[l].is_edge;
            mul_next[l].neg      = num[33] ^ den[33] ^ dif[33];
            mul_next[l].y1       = sel_reg[l].y1;
            mul_next[l].num_mag  = num[33] ? 32'(-num) : num[31:0];
            mul_next[l].diff_mag = dif[33] ? 33'(-dif) : dif[32:0];
            mul_next[l].den_mag  = den[33] ? 33'(-den) : den[32:0];
        end
    end

    // stage C: product, loaded into the divider
    always_comb begin
        logic [64:0] prod;
        for (int l = 0; l < 6; l++) begin
            prod = {33'd0, mul_reg[l].num_mag} * {32'd0, mul_reg[l].diff_mag};
            div0_next[l].is_edge = mul_reg[l].is_edge;
            div0_next[l].neg     = mul_reg[l].neg;
            div0_next[l].y1      = mul_reg[l].y1;
            div0_next[l].den     = mul_reg[l].den_mag;
            div0_next[l].rem     = prod[64:32];
            div0_next[l].low     = prod[31:0];
            div0_next[l].q       = '0;
        end
    end

    always_comb begin
        div_lane_t d;
        for (int l = 0; l < 6; l++) begin
            d = div_reg[l][NUM_DIV_STEPS];
            if (!d.is_edge) begin
                out_next[l] = d.y1;
            end else if (d.neg) begin
                out_next[l] = d.y1 - d.q;
            end else begin
                out_next[l] = d.y1 + d.q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg     <= {valid_reg[NCTL-2:0], s_valid};
            out_valid_reg <= valid_reg[NCTL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < NCTL; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            for (int l = 0; l < 6; l++) begin
                sel_reg[l]    <= sel_next[l];
                mul_reg[l]    <= mul_next[l];
                div_reg[l][0] <= div0_next[l];
                for (int k = 0; k < NUM_DIV_STEPS; k++) begin
                    div_reg[l][k+1] <= div_step(div_reg[l][k]);
                end
            end
            out_reg     <= out_next;
            out_ctl_reg <= ctl_reg[NCTL-1];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_entry_x     = out_reg[0];
    assign m_entry_y     = out_reg[1];
    assign m_entry_z     = out_reg[2];
    assign m_exit_x      = out_reg[3];
    assign m_exit_y      = out_reg[4];
    assign m_exit_z      = out_reg[5];
    assign m_entry_where = out_ctl_reg.entry_where;
    assign m_exit_where  = out_ctl_reg.exit_where;
    assign m_crossed     = (out_ctl_reg.entry_where != WHERE_NONE);

    `TCC_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, valid_reg[0], "accepted request missing in first stage")
    `TCC_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready, "input stalled with empty output")
    `TCC_ASSERT_NOW(a_edge_den_nonzero, aclk, aresetn, valid_reg[1] && mul_reg[0].is_edge, mul_reg[0].den_mag != '0, "edge crossing with zero span")
    `TCC_ASSERT_NOW(a_where_pair, aclk, aresetn, out_valid_reg, (out_ctl_reg.entry_where == WHERE_NONE) == (out_ctl_reg.exit_where == WHERE_NONE), "entry and exit codes disagree")

endmodule

FILE: tb/tb_triangle_contour_crossing_top.sv
// ----------------------------------------------------------------------------
// tb_triangle_contour_crossing_top
// Self-checking bench for the triangle isoline crossing block.
// A table of directed triangles, then random triangles under several contour
// levels. The levels include both extremes. Every result is checked field by
// field against an in-bench predictor or codes typed in. Random stalls are
// applied on both channels; one long receiver hold-off backs the pipeline up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_contour_crossing_top;
    import tcc_pkg::*;

    typedef struct {
        int val[3];
        int pos[3][3];
    } tri_t;

    typedef struct {
        logic signed [31:0] pt[2][3];
        logic [2:0]         where[2];
        logic               crossed;
    } xing_t;

    localparam int NDIR      = 16;
    localparam int LATENCY   = 36;
    localparam int MAX_CYC   = 400000;
    localparam int PHASE_LEN = 75;
    localparam int MINV      = 32'h8000_0000;
    localparam int MAXV      = 32'h7fff_ffff;
    localparam logic [2:0] VTX_CODE [3] = '{WHERE_V0, WHERE_V1, WHERE_V2};
    localparam logic [2:0] EDGE_CODE[3] = '{WHERE_E0, WHERE_E1, WHERE_E2};
    localparam int EDGE_END[3][2] = '{'{0, 1}, '{2, 1}, '{0, 2}};

    // values per row; rows flagged in dir_typed carry the codes typed in
    localparam int DIR_VAL[NDIR][3] = '{
        '{0, 0, 0}, '{0, 0, 5}, '{0, -1, 0}, '{7, 0, 0},
        '{0, -3, 4}, '{0, 2, 9}, '{-6, 0, 6}, '{5, -5, 0},
        '{-1, 1, -1}, '{-1, 1, 1}, '{1, 1, -1}, '{3, 4, 5},
        '{-3, -4, -5}, '{MINV, MAXV, 1}, '{MAXV, MINV, MINV}, '{MINV, 0, MAXV}
    };
    localparam bit DIR_TYPED[NDIR] = '{1, 1, 1, 1, 0, 1, 0, 0,
                                       0, 0, 0, 1, 1, 0, 0, 0};
    localparam logic [2:0] DIR_ENT[NDIR] = '{
        WHERE_NONE, WHERE_V0, WHERE_V0, WHERE_V1, WHERE_NONE, WHERE_NONE,
        WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE,
        WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE};
    localparam logic [2:0] DIR_EXT[NDIR] = '{
        WHERE_NONE, WHERE_V1, WHERE_V2, WHERE_V2, WHERE_NONE, WHERE_NONE,
        WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE,
        WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE, WHERE_NONE};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic signed [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_entry_x, m_entry_y, m_entry_z;
    logic signed [31:0] m_exit_x, m_exit_y, m_exit_z;
    logic [2:0] m_entry_where, m_exit_where;
    logic m_crossed;

    tri_t  cur_tri;
    xing_t crossing_q[$];
    int    level = 0;
    int    snd_idle_pct = 21;
    int    rcv_idle_pct = 78;
    bit    rcv_hold = 1'b0;
    int    mismatches = 0;
    int    cycles = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_crossed = 0;

    triangle_contour_crossing_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value_a(cur_tri.val[0]), .s_value_b(cur_tri.val[1]),
        .s_value_c(cur_tri.val[2]),
        .s_a_x(cur_tri.pos[0][0]), .s_a_y(cur_tri.pos[0][1]), .s_a_z(cur_tri.pos[0][2]),
        .s_b_x(cur_tri.pos[1][0]), .s_b_y(cur_tri.pos[1][1]), .s_b_z(cur_tri.pos[1][2]),
        .s_c_x(cur_tri.pos[2][0]), .s_c_y(cur_tri.pos[2][1]), .s_c_z(cur_tri.pos[2][2]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_entry_x(m_entry_x), .m_entry_y(m_entry_y), .m_entry_z(m_entry_z),
        .m_exit_x(m_exit_x), .m_exit_y(m_exit_y), .m_exit_z(m_exit_z),
        .m_entry_where(m_entry_where), .m_exit_where(m_exit_where),
        .m_crossed(m_crossed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     crossing_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] magn(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // truncating linear interpolation at the level along one coordinate
    function automatic logic signed [31:0] lerp(input longint x1, input longint x2,
                                                input longint y1, input longint y2,
                                                input longint lvl);
        longint      num, dif, den;
        logic [63:0] q;
        bit          neg;
        num = lvl - x1;
        dif = y2 - y1;
        den = x2 - x1;
        if (den == 0) return '0;
        q   = magn(num) * magn(dif) / magn(den);
        neg = ((num < 0) != (dif < 0)) != (den < 0);
        return neg ? 32'(y1 - longint'(q)) : 32'(y1 + longint'(q));
    endfunction

    function automatic void put_vertex(inout xing_t r, input int slot,
                                       input tri_t t, input int k);
        for (int i = 0; i < 3; i++) r.pt[slot][i] = t.pos[k][i];
        r.where[slot] = VTX_CODE[k];
    endfunction

    function automatic void put_edge(inout xing_t r, input int slot,
                                     input tri_t t, input int e, input int lvl);
        int p, q;
        p = EDGE_END[e][0];
        q = EDGE_END[e][1];
        for (int i = 0; i < 3; i++)
            r.pt[slot][i] = lerp(t.val[p], t.val[q], t.pos[p][i], t.pos[q][i], lvl);
        r.where[slot] = EDGE_CODE[e];
    endfunction

    function automatic bit same_xing(input xing_t a, input xing_t b);
        bit ok;
        ok = (a.crossed === b.crossed);
        for (int s = 0; s < 2; s++) begin
            if (a.where[s] !== b.where[s]) ok = 1'b0;
            for (int i = 0; i < 3; i++)
                if (a.pt[s][i] !== b.pt[s][i]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic xing_t predict_crossing(input tri_t t, input int lvl);
        xing_t  r, blank;
        longint d[3];
        bit     z[3], n[3], cr[3];
        int     slot;
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) blank.pt[k][i] = '0;
            blank.where[k] = WHERE_NONE;
        end
        blank.crossed = 1'b0;
        r = blank;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'(t.val[k]) - longint'(lvl);
            z[k] = (d[k] == 0);
            n[k] = (d[k] < 0);
        end
        r.crossed = 1'b1;
        if (z[0] && z[1] && z[2]) begin
            r.crossed = 1'b0;
        end else if (z[0] && z[1]) begin
            put_vertex(r, 0, t, 0); put_vertex(r, 1, t, 1);
        end else if (z[0] && z[2]) begin
            put_vertex(r, 0, t, 0); put_vertex(r, 1, t, 2);
        end else if (z[1] && z[2]) begin
            put_vertex(r, 0, t, 1); put_vertex(r, 1, t, 2);
        end else if (z[0]) begin
            if (n[1] != n[2]) begin
                put_vertex(r, 0, t, 0); put_edge(r, 1, t, 1, lvl);
            end else r.crossed = 1'b0;
        end else if (z[1]) begin
            if (n[0] != n[2]) begin
                put_vertex(r, 0, t, 1); put_edge(r, 1, t, 2, lvl);
            end else r.crossed = 1'b0;
        end else if (z[2]) begin
            if (n[0] != n[1]) begin
                put_vertex(r, 0, t, 2); put_edge(r, 1, t, 0, lvl);
            end else r.crossed = 1'b0;
        end else begin
            cr[0] = n[0] != n[1];
            cr[1] = n[1] != n[2];
            cr[2] = n[2] != n[0];
            slot = 0;
            for (int e = 0; e < 3; e++) begin
                if (cr[e] && slot < 2) begin
                    put_edge(r, slot, t, e, lvl);
                    slot++;
                end
            end
            if (slot != 2) r.crossed = 1'b0;
        end
        return r.crossed ? r : blank;
    endfunction

    always @(negedge aclk) begin
        m_ready <= rcv_hold ? 1'b0 : ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        xing_t exp_r, got;
        if (aresetn && m_valid && m_ready) begin
            got.pt[0] = '{m_entry_x, m_entry_y, m_entry_z};
            got.pt[1] = '{m_exit_x, m_exit_y, m_exit_z};
            got.where = '{m_entry_where, m_exit_where};
            got.crossed = m_crossed;
            if (crossing_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = crossing_q.pop_front();
                n_checked++;
                if (exp_r.crossed) n_crossed++;
                if (!same_xing(got, exp_r)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp %p got %p", n_checked, exp_r, got);
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_triangle(input tri_t t, input bit typed, input xing_t typed_r);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        cur_tri = t;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        crossing_q.insert(crossing_q.size(), typed ? typed_r : predict_crossing(t, level));
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (crossing_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_level(input int v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        level = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic tri_t random_triangle(input int lvl);
        tri_t t;
        int   mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            if (mode < 3) t.val[k] = $urandom;
            else if ($urandom_range(0, 3) == 0) t.val[k] = lvl;
            else if (mode < 7) t.val[k] = lvl + $urandom_range(0, 8) - 4;
            else t.val[k] = lvl + ($urandom_range(0, 1) ? 1 : -1) *
                            int'($urandom_range(1, 32'h3fff_ffff));
            for (int i = 0; i < 3; i++) t.pos[k][i] = $urandom;
        end
        return t;
    endfunction

    task automatic random_phase(input int lvl, input int count);
        xing_t dummy;
        write_level(lvl);
        repeat (count) send_triangle(random_triangle(lvl), 1'b0, dummy);
        s_valid = 1'b0;
        wait_idle();
    endtask

    initial begin
        tri_t  t;
        xing_t r;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) cur_tri.pos[k][i] = 0;
        cur_tri.val = '{0, 0, 0};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table at the reset level
        for (int row = 0; row < NDIR; row++) begin
            t.val = DIR_VAL[row];
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++)
                    t.pos[k][i] = (row == 14) ? ((k + i) % 2 ? MINV : MAXV)
                                  : (row * 977 + k * 65536 + i * 4099 - 70000);
            for (int s = 0; s < 2; s++) begin
                r.where[s] = s ? DIR_EXT[row] : DIR_ENT[row];
                for (int i = 0; i < 3; i++) r.pt[s][i] = '0;
                for (int k = 0; k < 3; k++)
                    if (r.where[s] == VTX_CODE[k])
                        for (int i = 0; i < 3; i++) r.pt[s][i] = t.pos[k][i];
            end
            r.crossed = DIR_ENT[row] != WHERE_NONE;
            send_triangle(t, DIR_TYPED[row], r);
        end
        s_valid = 1'b0;
        wait_idle();

        random_phase(MINV, PHASE_LEN);
        random_phase(MAXV, PHASE_LEN);
        snd_idle_pct = 78;
        rcv_idle_pct = 21;
        random_phase($urandom, PHASE_LEN);
        random_phase(-65536, PHASE_LEN);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        fork
            random_phase(32'h0001_8000, PHASE_LEN);
            begin
                repeat (10) @(posedge aclk);
                rcv_hold = 1'b1;
                repeat (200) @(posedge aclk);
                rcv_hold = 1'b0;
            end
        join
        random_phase(0, PHASE_LEN);

        $display("%0d triangles sent, %0d results checked, %0d crossed", n_sent,
                 n_checked, n_crossed);
        $display("contour levels: reset, both extremes, random; stalls on both sides");
        if (mismatches == 0 && crossing_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, crossing_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/triangle_contour_crossing_top.sv
tb/tb_triangle_contour_crossing_top.sv
